>>> hdl/pixel_color_mode_vote_top_macros.svh
// ----------------------------------------------------------------------------
// pixel_color_mode_vote_top_macros
// Assertion macros for the mode vote block.
// ----------------------------------------------------------------------------
`ifndef PIXEL_COLOR_MODE_VOTE_TOP_MACROS_SVH
`define PIXEL_COLOR_MODE_VOTE_TOP_MACROS_SVH
`ifndef SYNTH
`define PCMV_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define PCMV_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define PCMV_ASSERT_IMP(label, clk, rst_n, a, c)
`define PCMV_ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

>>> hdl/pcmv_pkg.sv
// ----------------------------------------------------------------------------
// pcmv_pkg
// Shared constants and types for the pixel colour mode vote block.
// ----------------------------------------------------------------------------
`default_nettype none
package pcmv_pkg;
    localparam int MAX_PHOTOS     = 8;
    localparam int NUM_PHOTOS_DEF = 8;
    localparam int COLOR_W        = 24;
    localparam int THR_W          = 8;
    localparam int DIST_W         = 18;
    localparam int COUNT_W        = 4;
    localparam logic [THR_W-1:0] THR_RESET = 8'd15;

    typedef logic [COLOR_W-1:0] color_t;

    // Squared BGR distance
    function automatic logic [DIST_W-1:0] dist2(input color_t a, input color_t b);
        logic [DIST_W-1:0] s;
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] d;
        s = '0;
        for (int ch = 0; ch < 3; ch++)
        begin
            x = a[8*ch +: 8];
            y = b[8*ch +: 8];
            d = (x > y) ? (x - y) : (y - x);
            s = s + DIST_W'({8'd0, d} * {8'd0, d});
        end
        return s;
    endfunction
endpackage
`default_nettype wire

>>> hdl/pcmv_core.sv
// ----------------------------------------------------------------------------
// pcmv_core
// Four-stage pipeline: pairwise match, cluster assignment, vote, agree mask.
// ----------------------------------------------------------------------------
`default_nettype none
`include "pixel_color_mode_vote_top_macros.svh"
module pcmv_core #(
    parameter int NUM_PHOTOS = pcmv_pkg::NUM_PHOTOS_DEF
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  en,
    input  wire                                  in_valid,
    input  wire  [NUM_PHOTOS*pcmv_pkg::COLOR_W-1:0] in_samples,
    input  wire  [2*pcmv_pkg::THR_W-1:0]         lim,
    output logic                                 out_valid,
    output pcmv_pkg::color_t                     out_color,
    output logic [pcmv_pkg::COUNT_W-1:0]         out_count,
    output logic [NUM_PHOTOS-1:0]                out_mask
);
    localparam int N = NUM_PHOTOS;
    localparam int IW = (N > 1) ? $clog2(N) : 1;

    pcmv_pkg::color_t smp [N];
    logic [3:0] v_reg;
    pcmv_pkg::color_t s1_reg [N];
    pcmv_pkg::color_t s2_reg [N];
    pcmv_pkg::color_t s3_reg [N];
    logic [N-1:0] m1_reg [N];
    logic [N-1:0] m1_next [N];
    logic [N-1:0] lead2_reg, lead2_next;
    logic [N-1:0] grp2_reg [N];
    logic [N-1:0] grp2_next [N];
    logic [IW-1:0] best3_reg, best3_next;
    logic [pcmv_pkg::COUNT_W-1:0] cnt3_reg, cnt3_next;
    logic [pcmv_pkg::COUNT_W-1:0] cnt4_reg;
    pcmv_pkg::color_t col4_reg;
    logic [N-1:0] mask4_reg, mask4_next;

    always_comb
    begin
        for (int i = 0; i < N; i++)
            smp[i] = in_samples[i*pcmv_pkg::COLOR_W +: pcmv_pkg::COLOR_W];
    end

    // Compare every later sample against every earlier one
    always_comb
    begin
        for (int i = 0; i < N; i++)
            for (int j = 0; j < N; j++)
                m1_next[i][j] = (j < i) &&
                    ({6'd0, pcmv_pkg::dist2(smp[j], smp[i])} < {8'd0, lim});
    end

    // Resolve greedy assignment: sample i opens a cluster unless it matches an
    // earlier leader; it joins the first matching leader
    always_comb
    begin
        logic [N-1:0] hit;
        lead2_next = '0;
        for (int i = 0; i < N; i++)
            grp2_next[i] = '0;
        for (int i = 0; i < N; i++)
        begin
            hit = m1_reg[i] & lead2_next;
            if (hit == '0)
            begin
                lead2_next[i] = 1'b1;
                grp2_next[i][i] = 1'b1;
            end
            else
            begin
                for (int j = N-1; j >= 0; j--)
                    if (hit[j])
                        grp2_next[i] = '0;
                for (int j = 0; j < N; j++)
                    if (hit[j] && ((hit & ((N'(1) << j) - N'(1))) == '0))
                        grp2_next[j][i] = 1'b1;
            end
        end
    end

    // Vote: largest group, earliest on ties
    always_comb
    begin
        logic [pcmv_pkg::COUNT_W-1:0] c;
        best3_next = '0;
        cnt3_next  = '0;
        for (int j = 0; j < N; j++)
        begin
            c = pcmv_pkg::COUNT_W'($countones(grp2_reg[j]));
            if (lead2_reg[j] && c > cnt3_next)
            begin
                cnt3_next  = c;
                best3_next = IW'(j);
            end
        end
    end

    // Agree mask against the chosen representative
    always_comb
    begin
        for (int i = 0; i < N; i++)
            mask4_next[i] = {6'd0, pcmv_pkg::dist2(s3_reg[i], s3_reg[best3_reg])}
                            < {8'd0, lim};
    end

    // Advance pipeline valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[2:0], in_valid};
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < N; i++)
            begin
                s1_reg[i]   <= smp[i];
                s2_reg[i]   <= s1_reg[i];
                s3_reg[i]   <= s2_reg[i];
                m1_reg[i]   <= m1_next[i];
                grp2_reg[i] <= grp2_next[i];
            end
            lead2_reg <= lead2_next;
            best3_reg <= best3_next;
            cnt3_reg  <= cnt3_next;
            cnt4_reg  <= cnt3_reg;
            col4_reg  <= s3_reg[best3_reg];
            mask4_reg <= mask4_next;
        end
    end

    assign out_valid = v_reg[3];
    assign out_color = col4_reg;
    assign out_count = cnt4_reg;
    assign out_mask  = mask4_reg;

    `PCMV_ASSERT_IMP(a_lead0, clk, rst_n, v_reg[1], lead2_reg[0])
    `PCMV_ASSERT_IMP(a_cnt, clk, rst_n, v_reg[1], (cnt3_next != 0) && (cnt3_next <= N))
    `PCMV_ASSERT_NEXT(a_hold, clk, rst_n, !en, $stable(v_reg))
endmodule
`default_nettype wire

>>> hdl/pixel_color_mode_vote_top.sv
// ----------------------------------------------------------------------------
// pixel_color_mode_vote_top
// Per-pixel colour mode vote over a stack of aligned photos.
// ----------------------------------------------------------------------------
// Channel   Direction  Content
// s_axis    in         tdata: sample_0 .. sample_N-1, 24 bits each
// m_axis    out        tdata: chosen_color, winner_count, agree_mask
// cfg       in         match_threshold, 8 bits
//
// One request per cycle unless the output stalls; requests pass through the
// core pipeline plus one output register. Reset sets the threshold to 15 and
// empties the pipeline. A stall on the output freezes the whole pipeline; the
// output register keeps accepting while its slot is empty.
// ----------------------------------------------------------------------------
`default_nettype none
`include "pixel_color_mode_vote_top_macros.svh"
module pixel_color_mode_vote_top #(
    parameter int NUM_PHOTOS = pcmv_pkg::NUM_PHOTOS_DEF
) (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         s_axis_tvalid,
    output logic                        s_axis_tready,
    // sample_0 at bits 23:0, then sample_1 .. sample_N-1
    input  wire  [NUM_PHOTOS*24-1:0]    s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  wire                         m_axis_tready,
    // chosen_color 23:0, winner_count 27:24, agree_mask 35:28, zero fill
    output logic [39:0]                 m_axis_tdata,
    input  wire                         cfg_valid,
    output logic                        cfg_ready,
    input  wire  [7:0]                  cfg_data
);
    logic [pcmv_pkg::THR_W-1:0] thr_reg;
    logic [2*pcmv_pkg::THR_W-1:0] lim_reg;
    logic en, cv;
    pcmv_pkg::color_t cc;
    logic [pcmv_pkg::COUNT_W-1:0] cn;
    logic [NUM_PHOTOS-1:0] cm;
    logic [39:0] out_reg;
    logic        ov_reg;

    assign cfg_ready = 1'b1;

    // Hold threshold and its square
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= pcmv_pkg::THR_RESET;
            lim_reg <= 16'(pcmv_pkg::THR_RESET * pcmv_pkg::THR_RESET);
        end
        else if (cfg_valid && cfg_ready)
        begin
            thr_reg <= cfg_data;
            lim_reg <= 16'({8'd0, cfg_data} * {8'd0, cfg_data});
        end
        else
            lim_reg <= 16'({8'd0, thr_reg} * {8'd0, thr_reg});
    end

    // Pipeline advances when the output slot is free or being drained
    assign en = !ov_reg || m_axis_tready;
    assign s_axis_tready = en;

    pcmv_core #(.NUM_PHOTOS(NUM_PHOTOS)) u_core (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(s_axis_tvalid),
        .in_samples(s_axis_tdata),
        .lim(lim_reg),
        .out_valid(cv), .out_color(cc), .out_count(cn), .out_mask(cm)
    );

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (en)
            ov_reg <= cv;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            out_reg <= {4'd0, 8'(cm), cn, cc};
    end

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = out_reg;

    `PCMV_ASSERT_NEXT(a_stall, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
    `PCMV_ASSERT_IMP(a_rdy, clk, rst_n, !m_axis_tvalid, s_axis_tready)
    `PCMV_ASSERT_IMP(a_cnt, clk, rst_n, m_axis_tvalid, m_axis_tdata[27:24] != 4'd0)
endmodule
`default_nettype wire

>>> tb/sv/tb_pixel_color_mode_vote_top.sv
// ----------------------------------------------------------------------------
// tb_pixel_color_mode_vote_top
// Stream test of the per-pixel colour mode vote: random bursts and output
// stalls, a local vote predictor, and a field by field check of every result.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_pixel_color_mode_vote_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NPH = 8;

    typedef struct packed {
        logic [7:0]  agree;
        logic [3:0]  count;
        logic [23:0] color;
    } vote_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [NPH*24-1:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [7:0] cfg_data = '0;

    logic [NPH*24-1:0] pixel_queue[$];
    vote_t vote_queue[$];
    logic [7:0] thr = pcmv_pkg::THR_RESET;
    int errors = 0;
    int votes_seen = 0;
    int stall_phase = 0;
    int burst_left = 0;
    int gap_left = 0;
    bit gaps_on = 1'b1;
    bit stalls_on = 1'b1;
    bit in_taken = 1'b0;

    pixel_color_mode_vote_top #(.NUM_PHOTOS(NPH)) dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        // sample_0 .. sample_7 from the lowest bit up
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        // chosen_color, winner_count, agree_mask, zero fill
        .m_axis_tdata(m_axis_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Append a pending pixel stack
    function automatic void add_pixel(logic [NPH*24-1:0] p);
        pixel_queue.insert(pixel_queue.size(), p);
    endfunction

    // Append an expected result
    function automatic void add_vote(vote_t v);
        vote_queue.insert(vote_queue.size(), v);
    endfunction

    // Squared BGR distance between two pixels
    function automatic int unsigned sq_dist(logic [23:0] a, logic [23:0] b);
        int unsigned s;
        int d;
        s = 0;
        for (int c = 0; c < 3; c++)
        begin
            d = int'(a[8*c +: 8]) - int'(b[8*c +: 8]);
            s += d * d;
        end
        return s;
    endfunction

    // Greedy clustering, largest cluster wins, earliest on ties
    function automatic vote_t mode_vote(logic [NPH*24-1:0] px, logic [7:0] t);
        logic [23:0] rep[NPH];
        int cnt[NPH];
        int ncl;
        int best;
        int unsigned lim;
        bit hit;
        vote_t v;
        ncl = 0;
        lim = t * t;
        for (int i = 0; i < NPH; i++)
        begin
            hit = 1'b0;
            for (int j = 0; j < ncl && !hit; j++)
                if (sq_dist(rep[j], px[24*i +: 24]) < lim)
                begin
                    cnt[j]++;
                    hit = 1'b1;
                end
            if (!hit)
            begin
                rep[ncl] = px[24*i +: 24];
                cnt[ncl] = 1;
                ncl++;
            end
        end
        best = 0;
        for (int j = 1; j < ncl; j++)
            if (cnt[j] > cnt[best])
                best = j;
        v.color = rep[best];
        v.count = 4'(cnt[best]);
        v.agree = '0;
        for (int i = 0; i < NPH; i++)
            v.agree[i] = sq_dist(px[24*i +: 24], rep[best]) < lim;
        return v;
    endfunction

    // Random pixel near a base colour
    function automatic logic [23:0] near(logic [23:0] base, int spread);
        logic [23:0] c;
        int x;
        for (int k = 0; k < 3; k++)
        begin
            x = int'(base[8*k +: 8]) + int'($urandom_range(2 * spread)) - spread;
            c[8*k +: 8] = (x < 0) ? 8'd0 : (x > 255) ? 8'd255 : 8'(x);
        end
        return c;
    endfunction

    // Record accepted requests and predict their results
    always @(posedge clk)
    begin
        in_taken = rst_n && s_axis_tvalid && s_axis_tready;
        if (in_taken)
        begin
            add_vote(mode_vote(s_axis_tdata, thr));
            void'(pixel_queue.pop_front());
        end
    end

    // Drive requests in bursts
    always @(negedge clk)
    begin
        if (rst_n && !(s_axis_tvalid && !in_taken))
        begin
            if (gap_left > 0)
                gap_left--;
            else if (burst_left == 0 && gaps_on)
            begin
                burst_left = $urandom_range(1, 20);
                gap_left = $urandom_range(0, 6);
            end
            if (pixel_queue.size() > 0 && (gap_left == 0 || !gaps_on))
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= pixel_queue[0];
                if (burst_left > 0)
                    burst_left--;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // Stall the output on a rotating pattern
    always @(negedge clk)
    begin
        stall_phase = (stall_phase + 1) % 23;
        m_axis_tready <= !stalls_on || (stall_phase < 11) || ($urandom_range(3) == 0);
    end

    // Compare each result with the oldest prediction
    always @(posedge clk)
    begin
        vote_t got;
        vote_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = vote_t'(m_axis_tdata[35:0]);
            votes_seen++;
            if (vote_queue.size() == 0)
            begin
                $error("unexpected result %h", m_axis_tdata);
                errors++;
            end
            else
            begin
                want = vote_queue.pop_front();
                if (got.color !== want.color)
                begin
                    $error("chosen_color exp %h got %h", want.color, got.color);
                    errors++;
                end
                if (got.count !== want.count)
                begin
                    $error("winner_count exp %0d got %0d", want.count, got.count);
                    errors++;
                end
                if (got.agree !== want.agree)
                begin
                    $error("agree_mask exp %b got %b", want.agree, got.agree);
                    errors++;
                end
                if (m_axis_tdata[39:36] !== 4'd0)
                begin
                    $error("fill exp 0 got %h", m_axis_tdata[39:36]);
                    errors++;
                end
            end
        end
    end

    task automatic drain();
        while (pixel_queue.size() > 0 || s_axis_tvalid || vote_queue.size() > 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic write_thr(logic [7:0] v);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        thr = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // One pixel stack: up to k clusters around random bases, mixed order
    function automatic logic [NPH*24-1:0] stacked(int k, int spread);
        logic [23:0] base[4];
        logic [NPH*24-1:0] px;
        for (int b = 0; b < 4; b++)
            base[b] = 24'($urandom);
        for (int i = 0; i < NPH; i++)
            px[24*i +: 24] = near(base[$urandom_range(k - 1)], spread);
        return px;
    endfunction

    initial
    begin
        logic [NPH*24-1:0] px;
        logic [7:0] thr_set[6];
        thr_set = '{8'd15, 8'd0, 8'd255, 8'd1, 8'd40, 8'd128};
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: extremes, ties, all alike, all distinct
        add_pixel('0);
        add_pixel('1);
        for (int i = 0; i < NPH; i++)
            px[24*i +: 24] = (i % 2) ? 24'hFFFFFF : 24'h000000;
        add_pixel(px);
        for (int i = 0; i < NPH; i++)
            px[24*i +: 24] = (i < 4) ? 24'h102030 : 24'hA0B0C0;
        add_pixel(px);
        for (int i = 0; i < NPH; i++)
            px[24*i +: 24] = 24'(24'h010101 * (i * 30));
        add_pixel(px);
        for (int i = 0; i < NPH; i++)
            px[24*i +: 24] = (i == 0) ? 24'h808080 : 24'(24'h80808A + i);
        add_pixel(px);
        for (int i = 0; i < NPH; i++)
            px[24*i +: 24] = (i < 3) ? 24'h0000FF : 24'hFF0000;
        add_pixel(px);
        add_pixel({NPH{24'hAAAAAA}});
        add_pixel({NPH{24'h555555}});
        drain();

        // Random phases, one per threshold
        for (int p = 0; p < 6; p++)
        begin
            write_thr(thr_set[p]);
            gaps_on = (p != 3);
            stalls_on = (p != 4);
            for (int n = 0; n < 250; n++)
            begin
                if ($urandom_range(9) == 0)
                    px = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
                else
                    px = stacked($urandom_range(1, 4), $urandom_range(0, 12));
                add_pixel(px);
            end
            drain();
        end

        $display("mode vote: %0d results checked over 6 thresholds incl. 0 and 255",
            votes_seen);
        if (errors == 0)
            $display("tb_pixel_color_mode_vote_top: clean");
        else
            $display("tb_pixel_color_mode_vote_top: errors");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("tb_pixel_color_mode_vote_top: errors");
        $finish;
    end
endmodule
`default_nettype wire
